### sv/ecc_pkg.sv
// Shared types, constants and helper functions for the elevator car controller.
package ecc_pkg;

    localparam int FLOORS     = 16;
    localparam int FLOOR_CNT  = (FLOORS >= 16) ? 16 : FLOORS;
    localparam int CFG_ADDR_W = 5;

    localparam logic [15:0] MAP_MASK  = 16'((17'd1 << FLOOR_CNT) - 17'd1);
    localparam logic [3:0]  TOP_FLOOR = 4'(FLOOR_CNT - 1);

    typedef enum logic [2:0] {
        CFG_CAR_ID,
        CFG_PARK_FLOOR,
        CFG_PEOPLE_LIMIT,
        CFG_BLOCK_TICKS,
        CFG_HELP_LIMIT,
        CFG_DOOR_HOLD,
        CFG_CLOSE_HOLD
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_UP,
        MODE_DOWN,
        MODE_OPEN,
        MODE_CLOSING,
        MODE_OVER,
        MODE_EMERG
    } car_mode_t;

    typedef enum logic [3:0] {
        KIND_TICK,
        KIND_HALL,
        KIND_PRESS,
        KIND_RELEASE,
        KIND_BOARD,
        KIND_LEAVE,
        KIND_HELP,
        KIND_EMERG,
        KIND_RESET
    } evt_kind_t;

    localparam logic [5:0] EV_FLOOR   = 6'b000001;
    localparam logic [5:0] EV_OPENED  = 6'b000010;
    localparam logic [5:0] EV_CLOSED  = 6'b000100;
    localparam logic [5:0] EV_BLOCKED = 6'b001000;
    localparam logic [5:0] EV_OVER    = 6'b010000;
    localparam logic [5:0] EV_EMERG   = 6'b100000;

    typedef struct packed {
        logic [3:0] car_id;
        logic [3:0] park_floor;
        logic [7:0] people_limit;
        logic [3:0] block_ticks;
        logic [7:0] help_limit;
        logic [7:0] door_hold;
        logic [7:0] close_hold;
    } cfg_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] car_select;
        logic       broadcast;
        logic [3:0] floor;
        logic [7:0] count;
    } item_t;

    typedef struct packed {
        logic [3:0]  cur_floor;
        logic [3:0]  goal_floor;
        logic [2:0]  car_mode;
        logic        last_up;
        logic [7:0]  riders;
        logic [4:0]  requests_pending;
        logic [15:0] buttons_lit;
        logic [5:0]  events;
        logic        accepted;
    } result_t;

    // Highest set bit of a floor map, zero when empty
    function automatic logic [3:0] highest_floor(input logic [15:0] map);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (map[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++)
        begin
            n = n + {4'd0, v[i]};
        end
        return n;
    endfunction

    // Safe floor clamped to the top floor
    function automatic logic [3:0] home_floor(input logic [3:0] safe);
        return (safe > TOP_FLOOR) ? TOP_FLOOR : safe;
    endfunction

endpackage

### sv/elevator_car_controller.sv
// Top level of the elevator car controller: input and result registers around the core.
//
// Usage:
//   Events enter on the input channel (in_valid/in_ready with mode, car_select,
//   broadcast, floor, count). Each transaction yields exactly one result on the
//   output channel (out_valid/out_ready) carrying the car's floor, goal, mode,
//   direction, riders, pending request count, lit buttons, event bits and the
//   accepted flag.
//   The event is registered in the input register at the accepting edge; once the
//   result register is free, the core updates the car state and loads the result
//   register. Throughput: one event per cycle while the receiver keeps taking
//   results; the core next-state logic is a single combinational pass.
//   When the receiver stalls, the result register holds; one more event can wait
//   in the input register, after which in_ready drops until the result is taken.
//   Configuration must be written over the APB port only while no event is in flight;
//   the block does not enforce this. Reset: rst_n clears both channels, the car state
//   (idle at floor 0, no requests, no riders) and loads the register defaults.
module elevator_car_controller
    import ecc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            mode,
    input  logic [3:0]            car_select,
    input  logic                  broadcast,
    input  logic [3:0]            floor,
    input  logic [7:0]            count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            cur_floor,
    output logic [3:0]            goal_floor,
    output logic [2:0]            car_mode,
    output logic                  last_up,
    output logic [7:0]            riders,
    output logic [4:0]            requests_pending,
    output logic [15:0]           buttons_lit,
    output logic [5:0]            events,
    output logic                  accepted
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_vld_reg, in_vld_next;
    logic    out_vld_reg, out_vld_next;
    result_t res_reg;
    result_t core_res;
    logic    advance;
    logic    fire;
    logic    in_take;

    ecc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    assign advance  = !out_vld_reg || out_ready;
    assign fire     = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind       <= mode;
            item_reg.car_select <= car_select;
            item_reg.broadcast  <= broadcast;
            item_reg.floor      <= floor;
            item_reg.count      <= count;
        end
        if (fire)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid        = out_vld_reg;
    assign cur_floor        = res_reg.cur_floor;
    assign goal_floor       = res_reg.goal_floor;
    assign car_mode         = res_reg.car_mode;
    assign last_up          = res_reg.last_up;
    assign riders           = res_reg.riders;
    assign requests_pending = res_reg.requests_pending;
    assign buttons_lit      = res_reg.buttons_lit;
    assign events           = res_reg.events;
    assign accepted         = res_reg.accepted;

endmodule

### sv/ecc_cfg.sv
// APB-style configuration register file for the elevator car controller.
module ecc_cfg
    import ecc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_idx_t idx;
    logic     wr_en;

    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                CFG_CAR_ID:       cfg_next.car_id       = pwdata[3:0];
                CFG_PARK_FLOOR:   cfg_next.park_floor   = pwdata[3:0];
                CFG_PEOPLE_LIMIT: cfg_next.people_limit = pwdata[7:0];
                CFG_BLOCK_TICKS:  cfg_next.block_ticks  = pwdata[3:0];
                CFG_HELP_LIMIT:   cfg_next.help_limit   = pwdata[7:0];
                CFG_DOOR_HOLD:    cfg_next.door_hold    = pwdata[7:0];
                CFG_CLOSE_HOLD:   cfg_next.close_hold   = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            CFG_CAR_ID:       prdata = {28'd0, cfg_reg.car_id};
            CFG_PARK_FLOOR:   prdata = {28'd0, cfg_reg.park_floor};
            CFG_PEOPLE_LIMIT: prdata = {24'd0, cfg_reg.people_limit};
            CFG_BLOCK_TICKS:  prdata = {28'd0, cfg_reg.block_ticks};
            CFG_HELP_LIMIT:   prdata = {24'd0, cfg_reg.help_limit};
            CFG_DOOR_HOLD:    prdata = {24'd0, cfg_reg.door_hold};
            CFG_CLOSE_HOLD:   prdata = {24'd0, cfg_reg.close_hold};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.car_id       <= 4'd1;
            cfg_reg.park_floor   <= 4'd0;
            cfg_reg.people_limit <= 8'd8;
            cfg_reg.block_ticks  <= 4'd3;
            cfg_reg.help_limit   <= 8'd3;
            cfg_reg.door_hold    <= 8'd3;
            cfg_reg.close_hold   <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/ecc_core.sv
// Car state registers and the single-pass next-state logic for one transaction.
module ecc_core
    import ecc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    car_mode_t   mode_reg,      mode_next;
    logic [3:0]  floor_reg,     floor_next;
    logic [3:0]  goal_reg,      goal_next;
    logic        up_reg,        up_next;
    logic [7:0]  riders_reg,    riders_next;
    logic [15:0] hall_reg,      hall_next;
    logic [15:0] button_reg,    button_next;
    logic [3:0]  block_reg,     block_next;
    logic        help_pend_reg, help_pend_next;
    logic [7:0]  help_cnt_reg,  help_cnt_next;
    logic        rescue_reg,    rescue_next;
    logic [7:0]  hold_reg,      hold_next;
    logic [5:0]  ev_next;
    logic        acc_next;

    // Next state of the car for the item held in the input register
    always_comb
    begin : next_state
        logic [15:0] all_map;
        logic [8:0]  help_sum;
        logic [8:0]  rider_sum;
        logic [3:0]  home_fl;
        logic [3:0]  tgt;
        logic [3:0]  fl_step;
        logic        here;
        logic        own;
        logic        fl_ok;
        car_mode_t   m;

        mode_next      = mode_reg;
        floor_next     = floor_reg;
        goal_next      = goal_reg;
        up_next        = up_reg;
        riders_next    = riders_reg;
        hall_next      = hall_reg;
        button_next    = button_reg;
        block_next     = block_reg;
        help_pend_next = help_pend_reg;
        help_cnt_next  = help_cnt_reg;
        rescue_next    = rescue_reg;
        hold_next      = hold_reg;
        ev_next        = '0;
        acc_next       = 1'b0;

        home_fl   = home_floor(cfg.park_floor);
        all_map   = (hall_reg | button_reg) & MAP_MASK;
        here      = item.broadcast || (item.car_select == cfg.car_id);
        own       = item.car_select == cfg.car_id;
        fl_ok     = {1'b0, item.floor} < 5'(FLOOR_CNT);
        help_sum  = {1'b0, help_cnt_reg} + 9'd1;
        rider_sum = {1'b0, riders_reg} + {1'b0, item.count};
        tgt       = '0;
        fl_step   = floor_reg;
        m         = mode_reg;

        if (fire)
        begin
            case (evt_kind_t'(item.kind))
                KIND_TICK:
                begin
                    acc_next = 1'b1;
                    if (hold_reg != 8'd0)
                    begin
                        hold_next = hold_reg - 8'd1;
                    end
                    else
                    begin
                        if (help_pend_reg)
                        begin
                            if (help_sum > {1'b0, cfg.help_limit})
                            begin
                                help_cnt_next  = 8'd1;
                                help_pend_next = 1'b0;
                                m              = MODE_EMERG;
                            end
                            else
                            begin
                                help_cnt_next = help_sum[7:0];
                            end
                        end
                        if (block_reg != 4'd0)
                        begin
                            block_next = block_reg - 4'd1;
                        end
                        mode_next = m;
                        case (m)
                            MODE_IDLE:
                            begin
                                tgt = (all_map != 16'd0) ? highest_floor(all_map) : goal_reg;
                                if (tgt == floor_reg && all_map[floor_reg])
                                begin
                                    mode_next = MODE_OPEN;
                                end
                                else
                                begin
                                    if (tgt == floor_reg)
                                    begin
                                        tgt = home_fl;
                                    end
                                    if (tgt > floor_reg)
                                    begin
                                        mode_next = MODE_UP;
                                    end
                                    else if (tgt < floor_reg)
                                    begin
                                        mode_next = MODE_DOWN;
                                    end
                                end
                                goal_next = tgt;
                            end
                            MODE_UP, MODE_DOWN:
                            begin
                                up_next = (m == MODE_UP);
                                if (m == MODE_UP)
                                begin
                                    if (floor_reg < TOP_FLOOR)
                                    begin
                                        fl_step = floor_reg + 4'd1;
                                    end
                                end
                                else if (floor_reg != 4'd0)
                                begin
                                    fl_step = floor_reg - 4'd1;
                                end
                                tgt = (all_map != 16'd0) ? highest_floor(all_map) : home_fl;
                                floor_next = fl_step;
                                goal_next  = tgt;
                                if (all_map[fl_step])
                                begin
                                    mode_next = MODE_OPEN;
                                end
                                else if (tgt == fl_step)
                                begin
                                    mode_next = MODE_IDLE;
                                end
                                else if (tgt > fl_step)
                                begin
                                    mode_next = MODE_UP;
                                end
                                else
                                begin
                                    mode_next = MODE_DOWN;
                                end
                                ev_next = EV_FLOOR;
                            end
                            MODE_OPEN:
                            begin
                                ev_next     = EV_OPENED;
                                hall_next   = hall_reg & ~(16'd1 << floor_reg);
                                button_next = button_reg & ~(16'd1 << floor_reg);
                                hold_next   = cfg.door_hold;
                                mode_next   = (riders_reg >= cfg.people_limit) ?
                                              MODE_OVER : MODE_CLOSING;
                            end
                            MODE_CLOSING:
                            begin
                                hold_next = cfg.close_hold;
                                // block count is looked at after this tick's decrement
                                if (block_next != 4'd0)
                                begin
                                    mode_next  = MODE_OPEN;
                                    ev_next    = EV_BLOCKED;
                                    block_next = 4'd0;
                                end
                                else
                                begin
                                    ev_next   = EV_CLOSED | EV_FLOOR;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_OVER:
                            begin
                                ev_next = EV_OVER;
                                if (riders_reg < cfg.people_limit)
                                begin
                                    mode_next = MODE_CLOSING;
                                end
                            end
                            MODE_EMERG:
                            begin
                                if (!rescue_reg)
                                begin
                                    ev_next     = EV_FLOOR | EV_EMERG;
                                    rescue_next = 1'b1;
                                end
                                if (floor_reg != home_fl)
                                begin
                                    floor_next = (home_fl > floor_reg) ?
                                                 floor_reg + 4'd1 : floor_reg - 4'd1;
                                    ev_next    = ev_next | EV_FLOOR;
                                end
                            end
                            default:
                            begin
                                mode_next = m;
                            end
                        endcase
                    end
                end
                KIND_HALL:
                begin
                    if (here && fl_ok)
                    begin
                        hall_next = hall_reg | (16'd1 << item.floor);
                        acc_next  = 1'b1;
                    end
                end
                KIND_PRESS:
                begin
                    if (own && fl_ok)
                    begin
                        button_next = button_reg | (16'd1 << item.floor);
                        acc_next    = 1'b1;
                    end
                end
                KIND_RELEASE:
                begin
                    if (own && fl_ok)
                    begin
                        button_next = button_reg & ~(16'd1 << item.floor);
                        acc_next    = 1'b1;
                    end
                end
                KIND_BOARD:
                begin
                    if (here)
                    begin
                        riders_next = rider_sum[8] ? 8'hFF : rider_sum[7:0];
                        block_next  = cfg.block_ticks;
                        acc_next    = 1'b1;
                    end
                end
                KIND_LEAVE:
                begin
                    if (here)
                    begin
                        riders_next = (item.count >= riders_reg) ?
                                      8'd0 : riders_reg - item.count;
                        block_next  = cfg.block_ticks;
                        acc_next    = 1'b1;
                    end
                end
                KIND_HELP:
                begin
                    if (here)
                    begin
                        help_pend_next = 1'b1;
                        acc_next       = 1'b1;
                    end
                end
                KIND_EMERG:
                begin
                    if (here && mode_reg != MODE_EMERG)
                    begin
                        // doors may be open: force them shut and hold
                        if (mode_reg != MODE_IDLE && mode_reg != MODE_UP &&
                            mode_reg != MODE_DOWN)
                        begin
                            ev_next   = EV_CLOSED;
                            hold_next = cfg.door_hold;
                        end
                        ev_next   = ev_next | EV_EMERG;
                        mode_next = MODE_EMERG;
                        acc_next  = 1'b1;
                    end
                end
                KIND_RESET:
                begin
                    if (here)
                    begin
                        mode_next   = MODE_IDLE;
                        button_next = '0;
                        hall_next   = '0;
                        goal_next   = home_fl;
                        rescue_next = 1'b0;
                        ev_next     = EV_EMERG;
                        acc_next    = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    // Result of the transaction, taken from the updated state
    always_comb
    begin
        result.cur_floor        = floor_next;
        result.goal_floor       = goal_next;
        result.car_mode         = mode_next;
        result.last_up          = up_next;
        result.riders           = riders_next;
        result.requests_pending = popcount16(hall_next);
        result.buttons_lit      = button_next;
        result.events           = ev_next;
        result.accepted         = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            floor_reg     <= '0;
            goal_reg      <= '0;
            up_reg        <= 1'b0;
            riders_reg    <= '0;
            hall_reg      <= '0;
            button_reg    <= '0;
            block_reg     <= '0;
            help_pend_reg <= 1'b0;
            help_cnt_reg  <= 8'd1;
            rescue_reg    <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            floor_reg     <= floor_next;
            goal_reg      <= goal_next;
            up_reg        <= up_next;
            riders_reg    <= riders_next;
            hall_reg      <= hall_next;
            button_reg    <= button_next;
            block_reg     <= block_next;
            help_pend_reg <= help_pend_next;
            help_cnt_reg  <= help_cnt_next;
            rescue_reg    <= rescue_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

### sv/ecc_checker.sv
// Port-level checker for the elevator car controller, bound to the top level.
module ecc_checker
    import ecc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [3:0]            mode,
    input logic [3:0]            car_select,
    input logic                  broadcast,
    input logic [3:0]            floor,
    input logic [7:0]            count,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [3:0]            cur_floor,
    input logic [3:0]            goal_floor,
    input logic [2:0]            car_mode,
    input logic                  last_up,
    input logic [7:0]            riders,
    input logic [4:0]            requests_pending,
    input logic [15:0]           buttons_lit,
    input logic [5:0]            events,
    input logic                  accepted
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cur_floor) &&
        $stable(car_mode) && $stable(events) && $stable(accepted))
        else $error("result changed while stalled");

    // a receiver that takes results never backs up the input side
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // door opening always leaves the car closing or overloaded
    a_open_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && events[1] |->
        car_mode == MODE_CLOSING || car_mode == MODE_OVER)
        else $error("door opened with wrong follow-on mode");

    // an ignored event reports nothing
    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> events == 6'd0)
        else $error("events reported for ignored transaction");

endmodule

bind elevator_car_controller ecc_checker u_ecc_checker (.*);

### bench/tb_elevator_car_controller.sv
// Self-checking testbench for elevator_car_controller: predicts every result and compares it.
module tb_elevator_car_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ecc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_IDLE     = 8;
    localparam int MAX_PRINTS   = 40;
    localparam int KIND_CODES   = 16;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [3:0]            mode;
    logic [3:0]            car_select;
    logic                  broadcast;
    logic [3:0]            floor;
    logic [7:0]            count;
    logic                  out_valid;
    logic                  out_ready;
    logic [3:0]            cur_floor;
    logic [3:0]            goal_floor;
    logic [2:0]            car_mode;
    logic                  last_up;
    logic [7:0]            riders;
    logic [4:0]            requests_pending;
    logic [15:0]           buttons_lit;
    logic [5:0]            events;
    logic                  accepted;

    // configuration as last written
    logic [3:0] cfg_car;
    logic [3:0] cfg_safe;
    logic [3:0] cfg_block;
    logic [7:0] cfg_people;
    logic [7:0] cfg_help;
    logic [7:0] cfg_door_hold;
    logic [7:0] cfg_close_hold;

    // car state as the controller should hold it
    car_mode_t   car_state;
    logic [3:0]  car_at;
    logic [3:0]  car_goal;
    logic [3:0]  doors_blocked;
    logic        car_rising;
    logic        help_raised;
    logic        rescue_done;
    logic [7:0]  car_riders;
    logic [7:0]  help_ticks;
    logic [7:0]  ticks_held;
    logic [15:0] hall_calls;
    logic [15:0] car_calls;

    result_t expected_status[$];
    result_t want_status;

    int fail_count         = 0;
    int cycle_count        = 0;
    int sender_max_gap     = MAX_IDLE;
    int receiver_max_stall = MAX_IDLE;
    int hold_off_cycles    = 0;
    int sink_stall;

    elevator_car_controller u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .car_select       (car_select),
        .broadcast        (broadcast),
        .floor            (floor),
        .count            (count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cur_floor        (cur_floor),
        .goal_floor       (goal_floor),
        .car_mode         (car_mode),
        .last_up          (last_up),
        .riders           (riders),
        .requests_pending (requests_pending),
        .buttons_lit      (buttons_lit),
        .events           (events),
        .accepted         (accepted)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_elevator_car_controller NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    task automatic reset_car_model();
        cfg_car        = 4'd1;
        cfg_safe       = 4'd0;
        cfg_people     = 8'd8;
        cfg_block      = 4'd3;
        cfg_help       = 8'd3;
        cfg_door_hold  = 8'd3;
        cfg_close_hold = 8'd1;
        car_state      = MODE_IDLE;
        car_at         = '0;
        car_goal       = '0;
        car_rising     = 1'b0;
        car_riders     = '0;
        hall_calls     = '0;
        car_calls      = '0;
        doors_blocked  = '0;
        help_raised    = 1'b0;
        help_ticks     = 8'd1;
        rescue_done    = 1'b0;
        ticks_held     = '0;
    endtask

    function automatic logic [3:0] top_call(input logic [15:0] calls);
        for (int i = 15; i >= 0; i--)
        begin
            if (calls[i])
            begin
                return 4'(i);
            end
        end
        return 4'd0;
    endfunction

    function automatic logic [3:0] home_stop();
        return (cfg_safe > TOP_FLOOR) ? TOP_FLOOR : cfg_safe;
    endfunction

    function automatic void steer();
        if (car_goal > car_at)
        begin
            car_state = MODE_UP;
        end
        else if (car_goal < car_at)
        begin
            car_state = MODE_DOWN;
        end
    endfunction

    // one floor of travel; the car stops at the shaft ends
    function automatic logic [5:0] travel(input logic up, input logic [15:0] calls);
        car_rising = up;
        if (up && car_at < TOP_FLOOR)
        begin
            car_at = car_at + 4'd1;
        end
        else if (!up && car_at > 4'd0)
        begin
            car_at = car_at - 4'd1;
        end
        car_goal = (calls != 0) ? top_call(calls) : home_stop();
        if (calls[car_at])
        begin
            car_state = MODE_OPEN;
        end
        else if (car_goal == car_at)
        begin
            car_state = MODE_IDLE;
        end
        else
        begin
            steer();
        end
        return EV_FLOOR;
    endfunction

    function automatic logic [5:0] tick_step();
        logic [15:0] calls;
        logic [5:0]  flags;
        int          next_help;
        flags = '0;
        // a pending hold swallows the tick whole
        if (ticks_held != 0)
        begin
            ticks_held = ticks_held - 8'd1;
            return flags;
        end
        calls = (hall_calls | car_calls) & MAP_MASK;
        if (help_raised)
        begin
            next_help = help_ticks + 1;
            if (next_help > cfg_help)
            begin
                help_ticks  = 8'd1;
                help_raised = 1'b0;
                car_state   = MODE_EMERG;
            end
            else
            begin
                help_ticks = 8'(next_help);
            end
        end
        if (doors_blocked != 0)
        begin
            doors_blocked = doors_blocked - 4'd1;
        end
        case (car_state)
            MODE_IDLE:
            begin
                if (calls != 0)
                begin
                    car_goal = top_call(calls);
                end
                if (car_goal == car_at && calls[car_at])
                begin
                    car_state = MODE_OPEN;
                end
                else
                begin
                    if (car_goal == car_at)
                    begin
                        car_goal = home_stop();
                    end
                    steer();
                end
            end
            MODE_UP:
            begin
                flags = travel(1'b1, calls);
            end
            MODE_DOWN:
            begin
                flags = travel(1'b0, calls);
            end
            MODE_OPEN:
            begin
                flags             = EV_OPENED;
                hall_calls[car_at] = 1'b0;
                car_calls[car_at]  = 1'b0;
                ticks_held        = cfg_door_hold;
                car_state         = (car_riders >= cfg_people) ? MODE_OVER : MODE_CLOSING;
            end
            MODE_CLOSING:
            begin
                ticks_held = cfg_close_hold;
                if (doors_blocked != 0)
                begin
                    flags         = EV_BLOCKED;
                    doors_blocked = '0;
                    car_state     = MODE_OPEN;
                end
                else
                begin
                    flags     = EV_CLOSED | EV_FLOOR;
                    car_state = MODE_IDLE;
                end
            end
            MODE_OVER:
            begin
                flags = EV_OVER;
                if (car_riders < cfg_people)
                begin
                    car_state = MODE_CLOSING;
                end
            end
            MODE_EMERG:
            begin
                if (!rescue_done)
                begin
                    flags       = EV_FLOOR | EV_EMERG;
                    rescue_done = 1'b1;
                end
                if (car_at != home_stop())
                begin
                    car_at = (home_stop() > car_at) ? car_at + 4'd1 : car_at - 4'd1;
                    flags  = flags | EV_FLOOR;
                end
            end
            default:
            begin
            end
        endcase
        return flags;
    endfunction

    function automatic result_t status_after(input logic [3:0] kind, input logic [3:0] sel,
                                             input logic bc, input logic [3:0] fl,
                                             input logic [7:0] cnt);
        result_t    r;
        logic       here;
        logic       own;
        logic       took;
        logic [5:0] flags;
        int         sum;
        own   = (sel == cfg_car);
        here  = bc || own;
        took  = 1'b0;
        flags = '0;
        case (kind)
            KIND_TICK:
            begin
                flags = tick_step();
                took  = 1'b1;
            end
            KIND_HALL:
            begin
                if (here && fl < FLOOR_CNT)
                begin
                    hall_calls[fl] = 1'b1;
                    took           = 1'b1;
                end
            end
            KIND_PRESS:
            begin
                if (own && fl < FLOOR_CNT)
                begin
                    car_calls[fl] = 1'b1;
                    took          = 1'b1;
                end
            end
            KIND_RELEASE:
            begin
                if (own && fl < FLOOR_CNT)
                begin
                    car_calls[fl] = 1'b0;
                    took          = 1'b1;
                end
            end
            KIND_BOARD:
            begin
                if (here)
                begin
                    sum           = car_riders + cnt;
                    car_riders    = (sum > 255) ? 8'hFF : 8'(sum);
                    doors_blocked = cfg_block;
                    took          = 1'b1;
                end
            end
            KIND_LEAVE:
            begin
                if (here)
                begin
                    car_riders    = (cnt >= car_riders) ? 8'd0 : car_riders - cnt;
                    doors_blocked = cfg_block;
                    took          = 1'b1;
                end
            end
            KIND_HELP:
            begin
                if (here)
                begin
                    help_raised = 1'b1;
                    took        = 1'b1;
                end
            end
            KIND_EMERG:
            begin
                if (here && car_state != MODE_EMERG)
                begin
                    // doors forced shut unless the car was parked or travelling
                    if (car_state != MODE_IDLE && car_state != MODE_UP
                        && car_state != MODE_DOWN)
                    begin
                        flags      = EV_CLOSED;
                        ticks_held = cfg_door_hold;
                    end
                    flags     = flags | EV_EMERG;
                    car_state = MODE_EMERG;
                    took      = 1'b1;
                end
            end
            KIND_RESET:
            begin
                if (here)
                begin
                    car_state   = MODE_IDLE;
                    car_calls   = '0;
                    hall_calls  = '0;
                    car_goal    = home_stop();
                    rescue_done = 1'b0;
                    flags       = EV_EMERG;
                    took        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.cur_floor        = car_at;
        r.goal_floor       = car_goal;
        r.car_mode         = car_state;
        r.last_up          = car_rising;
        r.riders           = car_riders;
        r.requests_pending = 5'($countones(hall_calls));
        r.buttons_lit      = car_calls;
        r.events           = flags;
        r.accepted         = took;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_PRINTS)
        begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                report_mismatch("result transaction with nothing outstanding");
            end
            else
            begin
                want_status = expected_status.pop_front();
                check_field("cur_floor", 16'(cur_floor), 16'(want_status.cur_floor));
                check_field("goal_floor", 16'(goal_floor), 16'(want_status.goal_floor));
                check_field("car_mode", 16'(car_mode), 16'(want_status.car_mode));
                check_field("last_up", 16'(last_up), 16'(want_status.last_up));
                check_field("riders", 16'(riders), 16'(want_status.riders));
                check_field("requests_pending", 16'(requests_pending),
                            16'(want_status.requests_pending));
                check_field("buttons_lit", buttons_lit, want_status.buttons_lit);
                check_field("events", 16'(events), 16'(want_status.events));
                check_field("accepted", 16'(accepted), 16'(want_status.accepted));
            end
        end
    end

    // result side: random stall per transaction, or one long hold-off when asked
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                sink_stall      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
            begin
                sink_stall = $urandom_range(receiver_max_stall);
            end
            if (sink_stall > 0)
            begin
                out_ready = 1'b0;
                repeat (sink_stall) @(negedge clk);
                out_ready = 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // valid is only dropped when a gap is drawn, so back-to-back items keep it high
    task automatic send_event(input logic [3:0] kind, input logic [3:0] sel, input logic bc,
                              input logic [3:0] fl, input logic [7:0] cnt);
        int gap;
        gap = $urandom_range(sender_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        mode       = kind;
        car_select = sel;
        broadcast  = bc;
        floor      = fl;
        count      = cnt;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_status.push_back(status_after(kind, sel, bc, fl, cnt));
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_CAR_ID:       cfg_car        = value[3:0];
            CFG_PARK_FLOOR:   cfg_safe       = value[3:0];
            CFG_PEOPLE_LIMIT: cfg_people     = value;
            CFG_BLOCK_TICKS:  cfg_block      = value[3:0];
            CFG_HELP_LIMIT:   cfg_help       = value;
            CFG_DOOR_HOLD:    cfg_door_hold  = value;
            CFG_CLOSE_HOLD:   cfg_close_hold = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [3:0] id, input logic [3:0] safe,
                              input logic [7:0] people, input logic [3:0] blk,
                              input logic [7:0] help, input logic [7:0] door_hold,
                              input logic [7:0] close_hold);
        write_reg(CFG_CAR_ID, {4'd0, id});
        write_reg(CFG_PARK_FLOOR, {4'd0, safe});
        write_reg(CFG_PEOPLE_LIMIT, people);
        write_reg(CFG_BLOCK_TICKS, {4'd0, blk});
        write_reg(CFG_HELP_LIMIT, help);
        write_reg(CFG_DOOR_HOLD, door_hold);
        write_reg(CFG_CLOSE_HOLD, close_hold);
    endtask

    // mostly ticks and ordinary passenger traffic, some alarms and junk events
    task automatic run_traffic(input int items);
        logic [3:0] kind;
        logic [3:0] sel;
        logic [3:0] fl;
        logic [7:0] cnt;
        logic       bc;
        int         pick;
        repeat (items)
        begin
            pick = $urandom_range(99);
            sel  = ($urandom_range(3) != 0) ? cfg_car : 4'($urandom_range(15));
            bc   = ($urandom_range(4) == 0);
            fl   = 4'($urandom_range(15));
            cnt  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
            if (pick < 50)
                kind = KIND_TICK;
            else if (pick < 62)
                kind = KIND_HALL;
            else if (pick < 72)
                kind = KIND_PRESS;
            else if (pick < 76)
                kind = KIND_RELEASE;
            else if (pick < 83)
                kind = KIND_BOARD;
            else if (pick < 90)
                kind = KIND_LEAVE;
            else if (pick < 92)
                kind = KIND_HELP;
            else if (pick < 94)
                kind = KIND_EMERG;
            else if (pick < 97)
                kind = KIND_RESET;
            else
                kind = 4'($urandom_range(KIND_CODES - 1, KIND_RESET + 1));
            send_event(kind, sel, bc, fl, cnt);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        set_config(4'd1, 4'd0, 8'd8, 4'd3, 8'd3, 8'd3, 8'd1);
        send_event(KIND_TICK, cfg_car, 1'b0, 4'd0, 8'd0);
        send_event(KIND_HALL, cfg_car, 1'b0, 4'd15, 8'd0);
        send_event(KIND_HALL, 4'd0, 1'b1, 4'd0, 8'd0);
        send_event(KIND_HALL, 4'd6, 1'b0, 4'd3, 8'd0);      // another car's call
        send_event(KIND_PRESS, cfg_car, 1'b0, 4'd15, 8'd0);
        send_event(KIND_PRESS, 4'd2, 1'b1, 4'd7, 8'd0);     // broadcast cannot press buttons
        send_event(KIND_RELEASE, cfg_car, 1'b0, 4'd15, 8'd0);
        send_event(KIND_BOARD, cfg_car, 1'b0, 4'd0, 8'd255);
        send_event(KIND_BOARD, 4'd0, 1'b1, 4'd0, 8'd255);   // rider count saturates
        send_event(KIND_LEAVE, cfg_car, 1'b0, 4'd0, 8'd0);
        send_event(KIND_LEAVE, cfg_car, 1'b0, 4'd0, 8'd255); // cannot go below empty
        send_event(KIND_BOARD, cfg_car, 1'b0, 4'd0, 8'd9);  // above the overload limit
        repeat (3) send_event(KIND_TICK, cfg_car, 1'b0, 4'd0, 8'd0);
        send_event(KIND_HELP, cfg_car, 1'b0, 4'd0, 8'd0);
        repeat (4) send_event(KIND_TICK, 4'd9, 1'b0, 4'd0, 8'd0);
        send_event(KIND_EMERG, cfg_car, 1'b0, 4'd0, 8'd0);
        send_event(KIND_EMERG, cfg_car, 1'b1, 4'd0, 8'd0);  // second alarm is refused
        send_event(KIND_RESET, 4'd0, 1'b1, 4'd0, 8'd0);
        send_event(KIND_RESET, 4'd3, 1'b0, 4'd0, 8'd0);     // not for this car
        send_event(4'(KIND_RESET + 1), cfg_car, 1'b1, 4'd5, 8'd1);
        send_event(4'(KIND_CODES - 1), cfg_car, 1'b1, 4'd10, 8'd2);
    endtask

    task automatic test_everyday_traffic();
        quiesce();
        set_config(4'd5, 4'd7, 8'd4, 4'd2, 8'd5, 8'd2, 8'd1);
        run_traffic(400);
    endtask

    task automatic test_lowest_settings();
        quiesce();
        set_config(4'd0, 4'd0, 8'd1, 4'd0, 8'd1, 8'd0, 8'd0);
        run_traffic(250);
    endtask

    task automatic test_highest_settings();
        quiesce();
        set_config(4'd15, 4'd15, 8'd255, 4'd15, 8'd255, 8'd255, 8'd255);
        run_traffic(150);
    endtask

    // result side holds off while events keep coming, so the input must back up
    task automatic test_result_stall();
        quiesce();
        set_config(4'd3, 4'd9, 8'd6, 4'd1, 8'd2, 8'd1, 8'd0);
        sender_max_gap  = 0;
        hold_off_cycles = 200;
        run_traffic(60);
        sender_max_gap = MAX_IDLE;
        run_traffic(150);
    endtask

    task automatic test_full_rate();
        quiesce();
        set_config(4'd10, 4'd4, 8'd3, 4'd4, 8'd4, 8'd1, 8'd2);
        sender_max_gap     = 0;
        receiver_max_stall = 0;
        run_traffic(200);
        sender_max_gap     = MAX_IDLE;
        receiver_max_stall = MAX_IDLE;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        mode       = '0;
        car_select = '0;
        broadcast  = 1'b0;
        floor      = '0;
        count      = '0;
        reset_car_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_everyday_traffic();
        test_lowest_settings();
        test_highest_settings();
        test_result_stall();
        test_full_rate();

        quiesce();
        if (fail_count == 0)
        begin
            $display("tb_elevator_car_controller OK");
        end
        else
        begin
            $display("tb_elevator_car_controller NOT OK");
        end
        $finish;
    end

endmodule
